FILE: hdl/bxfr_pkg.sv
// ----------------------------------------------------------------------------
// bxfr_pkg
// Shared types and constants for the bypass crossfade ramp.
// ----------------------------------------------------------------------------
package bxfr_pkg;

  // Width of the ramp length register and of the ramp position.
  localparam int LEN_W = 17;
  localparam logic [LEN_W-1:0] LEN_RESET = 17'd8192;

  // Last control value seen; the extra code means nothing seen yet.
  localparam logic [1:0] CTL_NONE = 2'd2;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_UP   = 2'd2
  } dir_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MIX  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

endpackage

FILE: hdl/bypass_crossfade_ramp_core.sv
// ----------------------------------------------------------------------------
// bypass_crossfade_ramp_core
// Stereo bypass crossfade: ramps the wet gain when the effect is switched.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                        | tuser
//  in_     | in  | dry_left, dry_right, wet_left, wet_right   | effect_on
//  out_    | out | out_left, out_right                        | is_bypassed, is_ramping
//  cfg_    | in  | cfg_wr_data = ramp_length, written on cfg_wr_en
//
// An item that mixes passes through the serial divider, then through the shared
// multiplier once per channel (difference, product, rounded sum), and then from
// ST_FIN into the output register. An item outside a ramp goes from ST_IDLE
// straight to ST_FIN and from there into the output register. in_tready is high
// only while no item is in work, so a new item is taken only after the last one
// has left ST_FIN; a finished result waits in the output register while the next
// item is taken, and a stalled receiver holds the next result until it drains.
// Reset is synchronous; it clears the ramp state and sets ramp_length to 8192.
// ----------------------------------------------------------------------------
module bypass_crossfade_ramp_core #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // dry_left, dry_right, wet_left, wet_right
  input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0]   in_tdata,
  // effect_on
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // out_left, out_right
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   out_tdata,
  // is_bypassed, is_ramping
  output logic [1:0]                            out_tuser,
  input  logic                                  cfg_wr_en,
  input  logic [bxfr_pkg::LEN_W-1:0]            cfg_wr_data
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int GF     = GAIN_FRAC_BITS;
  localparam int LW     = bxfr_pkg::LEN_W;
  localparam int OUT_DW = ((2*SAMPLE_WIDTH+7)/8)*8;

  bxfr_pkg::state_t state_r;
  bxfr_pkg::dir_t   dir_r;
  bxfr_pkg::dir_t   dir_mid;
  bxfr_pkg::dir_t   dir_nxt;

  logic [LW-1:0]  len_cfg_r;
  logic [1:0]     last_ctl_r;
  logic [LW-1:0]  pos_r;
  logic [LW-1:0]  pos_mid;
  logic [LW-1:0]  pos_nxt;
  logic [LW-1:0]  pos_eff;
  logic [LW-1:0]  len;
  logic           byp_r;
  logic           byp_mid;
  logic           byp_nxt;
  logic           active_r;
  logic           active_nxt;

  logic signed [SW-1:0] dry_l_r, dry_r_r, wet_l_r, wet_r_r;
  logic signed [SW-1:0] out_l_r, out_r_r;
  logic                 out_tvalid_r;
  logic [1:0]           out_flags_r;

  logic                 accept;
  logic                 ctl;
  logic                 div_done;
  logic [GF:0]          gain;
  logic                 mix_done;
  logic signed [SW-1:0] mix_left, mix_right;
  logic                 out_load;

  assign in_tready = (state_r == bxfr_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign ctl       = in_tuser;
  assign len       = (len_cfg_r == '0) ? LW'(1) : len_cfg_r;

  // Control check first, then one ramp step; the mix uses the new position.
  always_comb begin
    dir_mid = dir_r;
    pos_mid = pos_r;
    byp_mid = byp_r;
    if ({1'b0, ctl} != last_ctl_r) begin
      if (!ctl) begin
        if (dir_r == bxfr_pkg::DIR_IDLE) begin
          pos_mid = len;
        end
        dir_mid = bxfr_pkg::DIR_DOWN;
      end else begin
        if (dir_r == bxfr_pkg::DIR_IDLE) begin
          pos_mid = '0;
        end
        dir_mid = bxfr_pkg::DIR_UP;
        byp_mid = 1'b0;
      end
    end
    active_nxt = (dir_mid != bxfr_pkg::DIR_IDLE);
    dir_nxt    = dir_mid;
    pos_nxt    = pos_mid;
    byp_nxt    = byp_mid;
    case (dir_mid)
      bxfr_pkg::DIR_DOWN: begin
        if (pos_mid != '0) begin
          pos_nxt = pos_mid - LW'(1);
        end
        if (pos_nxt == '0) begin
          dir_nxt = bxfr_pkg::DIR_IDLE;
          byp_nxt = 1'b1;
        end
      end
      bxfr_pkg::DIR_UP: begin
        if (pos_mid < len) begin
          pos_nxt = pos_mid + LW'(1);
        end
        if (pos_nxt >= len) begin
          dir_nxt = bxfr_pkg::DIR_IDLE;
        end
      end
      default: ;
    endcase
    pos_eff = (pos_nxt < len) ? pos_nxt : len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= bxfr_pkg::LEN_RESET;
    end else if (cfg_wr_en) begin
      len_cfg_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bxfr_pkg::ST_IDLE;
      last_ctl_r   <= bxfr_pkg::CTL_NONE;
      dir_r        <= bxfr_pkg::DIR_IDLE;
      pos_r        <= '0;
      byp_r        <= 1'b0;
      active_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        bxfr_pkg::ST_IDLE: begin
          if (accept) begin
            last_ctl_r <= {1'b0, ctl};
            dir_r      <= dir_nxt;
            pos_r      <= pos_nxt;
            byp_r      <= byp_nxt;
            active_r   <= active_nxt;
            state_r    <= active_nxt ? bxfr_pkg::ST_DIV : bxfr_pkg::ST_FIN;
          end
        end
        bxfr_pkg::ST_DIV: begin
          if (div_done) begin
            state_r <= bxfr_pkg::ST_MIX;
          end
        end
        bxfr_pkg::ST_MIX: begin
          if (mix_done) begin
            state_r <= bxfr_pkg::ST_FIN;
          end
        end
        bxfr_pkg::ST_FIN: begin
          if (out_load) begin
            state_r <= bxfr_pkg::ST_IDLE;
          end
        end
        default: state_r <= bxfr_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dry_l_r <= in_tdata[SW-1:0];
      dry_r_r <= in_tdata[2*SW-1:SW];
      wet_l_r <= in_tdata[3*SW-1:2*SW];
      wet_r_r <= in_tdata[4*SW-1:3*SW];
    end
  end

  assign out_load = (state_r == bxfr_pkg::ST_FIN) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (active_r) begin
        out_l_r <= mix_left;
        out_r_r <= mix_right;
      end else begin
        out_l_r <= byp_r ? dry_l_r : wet_l_r;
        out_r_r <= byp_r ? dry_r_r : wet_r_r;
      end
      out_flags_r <= {dir_r != bxfr_pkg::DIR_IDLE, byp_r};
    end
  end

  bxfr_gain_div #(
    .GAIN_FRAC_BITS(GF)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept && active_nxt),
    .pos   (pos_eff),
    .len   (len),
    .done  (div_done),
    .gain  (gain)
  );

  bxfr_mix_unit #(
    .SAMPLE_WIDTH  (SW),
    .GAIN_FRAC_BITS(GF)
  ) u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_done),
    .gain      (gain),
    .dry_left  (dry_l_r),
    .dry_right (dry_r_r),
    .wet_left  (wet_l_r),
    .wet_right (wet_r_r),
    .done      (mix_done),
    .mix_left  (mix_left),
    .mix_right (mix_right)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DW'({out_r_r, out_l_r});
  assign out_tuser  = out_flags_r;

endmodule

FILE: hdl/bxfr_gain_div.sv
// ----------------------------------------------------------------------------
// bxfr_gain_div
// Restoring divider for the wet gain g = pos * 2^FRAC / len, one bit a cycle.
// ----------------------------------------------------------------------------
module bxfr_gain_div #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [bxfr_pkg::LEN_W-1:0]     pos,
  input  logic [bxfr_pkg::LEN_W-1:0]     len,
  output logic                           done,
  output logic [GAIN_FRAC_BITS:0]        gain
);

  localparam int LW = bxfr_pkg::LEN_W;
  localparam int CW = $clog2(GAIN_FRAC_BITS + 1);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [LW-1:0]     rem_r;
  logic [LW-1:0]     len_r;
  logic [GAIN_FRAC_BITS:0] q_r;

  logic [LW:0] trial;
  logic [LW:0] diff;
  logic        geq;

  assign trial = {rem_r, 1'b0};
  assign diff  = trial - {1'b0, len_r};
  assign geq   = trial >= {1'b0, len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // The integer part of the quotient is 1 only when pos is at least len, and then
  // the remainder is zero, so every fraction bit comes out 0.
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CW'(GAIN_FRAC_BITS);
      len_r <= len;
      if (pos >= len) begin
        rem_r <= '0;
        q_r   <= (GAIN_FRAC_BITS+1)'(1);
      end else begin
        rem_r <= pos;
        q_r   <= '0;
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (geq) begin
        rem_r <= diff[LW-1:0];
        q_r   <= {q_r[GAIN_FRAC_BITS-1:0], 1'b1};
      end else begin
        rem_r <= trial[LW-1:0];
        q_r   <= {q_r[GAIN_FRAC_BITS-1:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign gain = q_r;

endmodule

FILE: hdl/bxfr_mix_unit.sv
// ----------------------------------------------------------------------------
// bxfr_mix_unit
// One multiplier shared by both channels: out = dry + (wet - dry) * g,
// rounded to nearest and saturated.
// ----------------------------------------------------------------------------
module bxfr_mix_unit #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [GAIN_FRAC_BITS:0]        gain,
  input  logic signed [SAMPLE_WIDTH-1:0] dry_left,
  input  logic signed [SAMPLE_WIDTH-1:0] dry_right,
  input  logic signed [SAMPLE_WIDTH-1:0] wet_left,
  input  logic signed [SAMPLE_WIDTH-1:0] wet_right,
  output logic                           done,
  output logic signed [SAMPLE_WIDTH-1:0] mix_left,
  output logic signed [SAMPLE_WIDTH-1:0] mix_right
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int GF = GAIN_FRAC_BITS;
  localparam int AW = SW + GF + 3;
  localparam int RW = SW + 3;

  localparam logic signed [RW-1:0] SAT_HI = {4'b0000, {(SW-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = {4'b1111, {(SW-1){1'b0}}};
  localparam logic signed [AW-1:0] HALF   = AW'(1) <<< (GF - 1);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_DIFF = 4'b0010,
    M_MUL  = 4'b0100,
    M_SUM  = 4'b1000
  } mix_state_t;

  mix_state_t              mst_r;
  logic                    chan_r;
  logic                    done_r;
  logic [GF:0]             g_r;
  logic signed [SW:0]      diff_r;
  logic signed [AW-1:0]    prod_r;
  logic signed [SW-1:0]    left_r;
  logic signed [SW-1:0]    right_r;

  logic signed [SW-1:0]    sel_dry;
  logic signed [SW-1:0]    sel_wet;
  logic signed [AW-1:0]    acc;
  logic signed [RW-1:0]    rnd;
  logic signed [SW-1:0]    sat;

  assign sel_dry = chan_r ? dry_right : dry_left;
  assign sel_wet = chan_r ? wet_right : wet_left;

  always_comb begin
    acc = (AW'(sel_dry) <<< GF) + prod_r + HALF;
    rnd = acc[AW-1:GF];
    if (rnd > SAT_HI) begin
      sat = SAT_HI[SW-1:0];
    end else if (rnd < SAT_LO) begin
      sat = SAT_LO[SW-1:0];
    end else begin
      sat = rnd[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mst_r  <= M_IDLE;
      chan_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (mst_r)
        M_IDLE: begin
          if (start) begin
            chan_r <= 1'b0;
            mst_r  <= M_DIFF;
          end
        end
        M_DIFF: mst_r <= M_MUL;
        M_MUL:  mst_r <= M_SUM;
        M_SUM: begin
          if (chan_r) begin
            done_r <= 1'b1;
            mst_r  <= M_IDLE;
          end else begin
            chan_r <= 1'b1;
            mst_r  <= M_DIFF;
          end
        end
        default: mst_r <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && mst_r == M_IDLE) begin
      g_r <= gain;
    end
    if (mst_r == M_DIFF) begin
      diff_r <= (SW+1)'(sel_wet) - (SW+1)'(sel_dry);
    end
    if (mst_r == M_MUL) begin
      prod_r <= diff_r * $signed({1'b0, g_r});
    end
    if (mst_r == M_SUM) begin
      if (chan_r) begin
        right_r <= sat;
      end else begin
        left_r <= sat;
      end
    end
  end

  assign done      = done_r;
  assign mix_left  = left_r;
  assign mix_right = right_r;

endmodule
